// ===== rtl/m3if_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3if_pkg: shared types and constants of the three-tap impulse filter
// Sample and threshold widths, ring geometry, fill levels and the record
// carried from the input register to the result stage.
// ----------------------------------------------------------------------------
package m3if_pkg;

   localparam int SampleWidth = 32;
   localparam int ThreshWidth = 31;
   localparam int RingDepth   = 3;
   localparam int SlotWidth   = 2;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic        [ThreshWidth-1:0] thresh_type;
   typedef logic        [SlotWidth-1:0]   slot_type;
   typedef logic        [1:0]             fill_type;

   // Ring slots and fill levels.
   localparam slot_type SLOT_FIRST = 2'd0;
   localparam slot_type SLOT_LAST  = slot_type'(RingDepth - 1);
   localparam fill_type FILL_EMPTY = 2'd0;
   localparam fill_type FILL_ONE   = 2'd1;
   localparam fill_type FILL_TWO   = 2'd2;
   localparam fill_type FILL_FULL  = fill_type'(RingDepth);

   // Snapshot of one sample and the ring contents after it was written.
   typedef struct packed {
      sample_type              sample;
      sample_type [RingDepth-1:0] ring;
      fill_type                fill;
   } stage_type;

endpackage

// ===== rtl/median3_impulse_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median3_impulse_filter: switching median filter for salt-and-pepper noise
//
// Usage: samples arrive on the req_ channel (req_valid, req_stall,
// req_sample) and one filtered sample per input leaves on the rsp_ channel
// (rsp_valid, rsp_stall, rsp_filtered). A transfer happens on a rising edge
// with valid high and stall low. The threshold is written through csr_valid,
// csr_ready and csr_data while the filter is idle; csr_ready is always high.
// A sample passes through one input register holding the sample and a
// snapshot of the ring, then the result register. Throughput is one sample
// per cycle; the limit is the single result register, which reloads every
// cycle while rsp_stall is low. While the receiver stalls, the result holds
// steady, one more sample can be taken into the input register, and
// req_stall rises after that. Synchronous reset empties both stages,
// clears the fill count and write slot, and sets the threshold to zero.
// ----------------------------------------------------------------------------
module median3_impulse_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  m3if_pkg::sample_type   req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output m3if_pkg::sample_type   rsp_filtered,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  m3if_pkg::thresh_type   csr_data
);

   m3if_pkg::thresh_type                          thresh_ff;
   m3if_pkg::slot_type                            slot_ff, slot_in;
   m3if_pkg::fill_type                            fill_ff, fill_in;
   m3if_pkg::sample_type [m3if_pkg::RingDepth-1:0] ring_ff, ring_in;
   m3if_pkg::stage_type                           stage_ff, stage_in;
   logic                                          stage_valid_ff;
   logic                                          rsp_valid_ff;
   m3if_pkg::sample_type                          rsp_filtered_ff, rsp_filtered_in;
   logic                                          req_take;
   logic                                          rsp_load;

   logic signed [m3if_pkg::SampleWidth:0]   pair_sum;
   logic signed [m3if_pkg::SampleWidth:0]   pair_half;
   m3if_pkg::sample_type                    lo_val, hi_val, mid_val, ref_val;
   logic signed [m3if_pkg::SampleWidth:0]   dev;
   logic        [m3if_pkg::SampleWidth:0]   dev_abs;

   // Handshake: the result register reloads when empty or when its transfer
   // completes; the input register moves on whenever the result reloads.
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_data;
      end
   end

   // Ring write, slot advance and saturating fill count.
   always_comb begin
      ring_in = ring_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (req_take) begin
         for (int i = 0; i < m3if_pkg::RingDepth; i++) begin
            if (slot_ff == m3if_pkg::slot_type'(i)) begin
               ring_in[i] = req_sample;
            end
         end
         if (slot_ff >= m3if_pkg::SLOT_LAST) begin
            slot_in = m3if_pkg::SLOT_FIRST;
         end else begin
            slot_in = slot_ff + 2'd1;
         end
         if (fill_ff != m3if_pkg::FILL_FULL) begin
            fill_in = fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= m3if_pkg::SLOT_FIRST;
         fill_ff <= m3if_pkg::FILL_EMPTY;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
   end

   // Input register: the new sample with the ring as it stands after it.
   assign stage_in.sample = req_sample;
   assign stage_in.ring   = ring_in;
   assign stage_in.fill   = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_take) begin
         stage_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
   end

   // Mean of the first two samples, truncated toward zero.
   always_comb begin
      pair_sum  = {stage_ff.ring[0][m3if_pkg::SampleWidth-1], stage_ff.ring[0]}
                + {stage_ff.ring[1][m3if_pkg::SampleWidth-1], stage_ff.ring[1]};
      pair_half = (pair_sum >>> 1)
                + $signed({{m3if_pkg::SampleWidth{1'b0}},
                           pair_sum[m3if_pkg::SampleWidth] & pair_sum[0]});
   end

   // Median of three: clamp the third entry between the other two.
   always_comb begin
      if (stage_ff.ring[0] < stage_ff.ring[1]) begin
         lo_val = stage_ff.ring[0];
         hi_val = stage_ff.ring[1];
      end else begin
         lo_val = stage_ff.ring[1];
         hi_val = stage_ff.ring[0];
      end
      if (stage_ff.ring[2] <= lo_val) begin
         mid_val = lo_val;
      end else if (stage_ff.ring[2] >= hi_val) begin
         mid_val = hi_val;
      end else begin
         mid_val = stage_ff.ring[2];
      end
   end

   // Reference selection by fill level.
   always_comb begin
      case (stage_ff.fill)
         m3if_pkg::FILL_ONE: ref_val = stage_ff.ring[0];
         m3if_pkg::FILL_TWO: ref_val = pair_half[m3if_pkg::SampleWidth-1:0];
         default:            ref_val = mid_val;
      endcase
   end

   // Absolute deviation, formed one bit wider so it cannot overflow.
   always_comb begin
      dev = {stage_ff.sample[m3if_pkg::SampleWidth-1], stage_ff.sample}
          - {ref_val[m3if_pkg::SampleWidth-1], ref_val};
      if (dev[m3if_pkg::SampleWidth]) begin
         dev_abs = $unsigned(-dev);
      end else begin
         dev_abs = $unsigned(dev);
      end
      if (dev_abs > {{(m3if_pkg::SampleWidth + 1 - m3if_pkg::ThreshWidth){1'b0}},
                     thresh_ff}) begin
         rsp_filtered_in = ref_val;
      end else begin
         rsp_filtered_in = stage_ff.sample;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && stage_valid_ff) begin
         rsp_filtered_ff <= rsp_filtered_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

// ===== rtl/m3if_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3if_checker: port-level checks for the three-tap impulse filter
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module m3if_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input m3if_pkg::sample_type req_sample,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input m3if_pkg::sample_type rsp_filtered
);

   // Reset leaves no result pending.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result stays and does not change.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered))
      else $error("stalled result changed or vanished");

   // With no result waiting, the input side is never stalled.
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   // A transfer in, followed by an unstalled result side, makes a result valid.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after input transfer");

   // A transferred sample carries no unknown bits.
   a_req_known : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !$isunknown(req_sample))
      else $error("unknown sample transferred");

endmodule

bind median3_impulse_filter m3if_checker u_m3if_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_sample   (req_sample),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_filtered (rsp_filtered)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-tap switching median filter
// A directed table covers the fill-up after reset, the field extremes, the
// truncating mean of two, the wide difference and the threshold extremes.
// Random phases follow: a drifting signal with noise, salt and pepper
// impulses and raw words, under several thresholds. Both channels idle at
// random, and one phase holds the result side off for a long stretch.
// Every result transfer is compared with a cycle-free prediction of the
// filter.
// ----------------------------------------------------------------------------
module tb;

   localparam int                   PHASES           = 10;
   localparam int                   PHASE_ITEMS      = 100;
   localparam int                   MAX_PAUSE        = 18;
   localparam int                   LONG_HOLD_CYCLES = 150;
   localparam int                   DRAIN_CYCLES     = 8;
   localparam int                   CYCLE_LIMIT      = 300000;
   localparam int                   REPORT_LIMIT     = 10;
   localparam m3if_pkg::sample_type SAMPLE_MAX       = 32'sh7FFFFFFF;
   localparam m3if_pkg::sample_type SAMPLE_MIN       = 32'sh80000000;
   localparam m3if_pkg::thresh_type THRESH_MAX       = '1;

   typedef enum bit {ROW_SAMPLE, ROW_THRESHOLD} row_kind_type;

   // One line of the directed table: a sample or a threshold write.
   typedef struct packed {
      row_kind_type         kind;
      logic [31:0]          value;
      logic                 typed;
      m3if_pkg::sample_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   m3if_pkg::sample_type req_sample   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b1;
   m3if_pkg::sample_type rsp_filtered;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   m3if_pkg::thresh_type csr_data     = '0;

   // Side controls for idling and the long hold.
   logic       rx_idle      = 1'b1;
   logic       hold_request = 1'b0;
   int         hold_left    = 0;
   int         rx_wait      = 0;
   bit         tx_idle      = 1'b1;

   // Filter state as the bench sees it.
   m3if_pkg::sample_type ring_copy [m3if_pkg::RingDepth];
   m3if_pkg::slot_type   slot_copy     = m3if_pkg::SLOT_FIRST;
   m3if_pkg::fill_type   fill_copy     = m3if_pkg::FILL_EMPTY;
   m3if_pkg::thresh_type impulse_limit = '0;

   m3if_pkg::sample_type expected_filtered [$];
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   longint               signal_level   = 0;
   longint               noise_span     = 8;
   stim_row_type         directed_rows [24];

   median3_impulse_filter uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Long hold-off of the result side, counted here once requested.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request) begin
         hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result side: after each transfer draw how many cycles to stall.
   always @(posedge clock) begin : result_side
      int unsigned pause;
      if (reset) begin
         rsp_stall <= 1'b1;
         rx_wait   <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         pause     = rx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
         rx_wait   <= int'(pause);
         rsp_stall <= (pause != 0);
      end else if (rx_wait != 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_stall <= (rx_wait != 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result check against the oldest outstanding expectation.
   always @(posedge clock) begin : result_check
      m3if_pkg::sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_filtered.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result transfer: filtered %0d", rsp_filtered);
         end else begin
            want = expected_filtered.pop_front();
            if (rsp_filtered !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("filtered mismatch: expected %0d, got %0d", want, rsp_filtered);
            end
         end
      end
   end

   // Writes the sample into the ring copy and works out the filtered value.
   function automatic m3if_pkg::sample_type predict_filtered(m3if_pkg::sample_type x);
      longint               reference;
      longint               deviation;
      m3if_pkg::sample_type lo;
      m3if_pkg::sample_type hi;
      ring_copy[slot_copy] = x;
      slot_copy = (slot_copy == m3if_pkg::SLOT_LAST) ? m3if_pkg::SLOT_FIRST
                                                     : m3if_pkg::slot_type'(slot_copy + 1);
      if (fill_copy != m3if_pkg::FILL_FULL)
         fill_copy = m3if_pkg::fill_type'(fill_copy + 1);
      case (fill_copy)
         m3if_pkg::FILL_ONE: begin
            reference = longint'(ring_copy[0]);
         end
         m3if_pkg::FILL_TWO: begin
            // Integer division truncates toward zero, as the mean requires.
            reference = (longint'(ring_copy[0]) + longint'(ring_copy[1])) / 2;
         end
         default: begin
            lo = (ring_copy[0] < ring_copy[1]) ? ring_copy[0] : ring_copy[1];
            hi = (ring_copy[0] < ring_copy[1]) ? ring_copy[1] : ring_copy[0];
            if (ring_copy[2] <= lo)
               reference = longint'(lo);
            else if (ring_copy[2] >= hi)
               reference = longint'(hi);
            else
               reference = longint'(ring_copy[2]);
         end
      endcase
      deviation = longint'(x) - reference;
      if (deviation < 0)
         deviation = -deviation;
      return (deviation > longint'(impulse_limit)) ? m3if_pkg::sample_type'(reference[31:0])
                                                   : x;
   endfunction

   function automatic m3if_pkg::sample_type clamp_sample(longint v);
      if (v > longint'(SAMPLE_MAX))
         return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN))
         return SAMPLE_MIN;
      return m3if_pkg::sample_type'(v[31:0]);
   endfunction

   // Random offset in the range -span..span, span capped at 31 bits.
   function automatic longint random_offset(longint span);
      longint capped;
      longint offset;
      capped = (span > longint'(SAMPLE_MAX)) ? longint'(SAMPLE_MAX) : span;
      offset = longint'($urandom_range(0, unsigned'(int'(capped))));
      return ($urandom_range(0, 1) != 0) ? offset : -offset;
   endfunction

   // Mostly a drifting noisy signal, with impulses, corners and raw words.
   function automatic m3if_pkg::sample_type next_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return SAMPLE_MAX;
      if (pick < 10)
         return SAMPLE_MIN;
      if (pick < 15)
         return clamp_sample(signal_level + random_offset(noise_span) * 4
                             + ((noise_span + 1) * (($urandom_range(0, 1) != 0) ? 3 : -3)));
      if (pick < 25)
         return m3if_pkg::sample_type'($urandom());
      if (pick < 28) begin
         case ($urandom_range(0, 4))
            0:       return '0;
            1:       return -1;
            2:       return 1;
            3:       return SAMPLE_MIN + 1;
            default: return SAMPLE_MAX - 1;
         endcase
      end
      signal_level = longint'(clamp_sample(signal_level + random_offset(noise_span / 8 + 1)));
      return clamp_sample(signal_level + random_offset(noise_span));
   endfunction

   // Offers one sample; the prediction is queued at the transfer edge.
   task automatic send_sample(input m3if_pkg::sample_type x, input logic typed,
                              input m3if_pkg::sample_type want);
      int unsigned          gap;
      m3if_pkg::sample_type predicted;
      gap = tx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
      if (gap != 0) begin
         req_valid  <= 1'b0;
         req_sample <= m3if_pkg::sample_type'($urandom());
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (req_stall);
      predicted = predict_filtered(x);
      expected_filtered.push_back(typed ? want : predicted);
   endtask

   // Threshold writes happen only once every expected result has arrived.
   task automatic write_threshold(input m3if_pkg::thresh_type value);
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      impulse_limit = value;
   endtask

   initial begin
      // Directed rows: fill-up after reset first, then threshold extremes.
      directed_rows = '{
         '{ROW_SAMPLE,    SAMPLE_MAX,   1'b1, SAMPLE_MAX},
         '{ROW_SAMPLE,    SAMPLE_MIN,   1'b1, 32'sd0},
         '{ROW_SAMPLE,    SAMPLE_MIN,   1'b1, SAMPLE_MIN},
         '{ROW_SAMPLE,    SAMPLE_MAX,   1'b1, SAMPLE_MIN},
         '{ROW_SAMPLE,    32'd0,        1'b0, '0},
         '{ROW_SAMPLE,    32'hFFFFFFFF, 1'b0, '0},
         '{ROW_SAMPLE,    32'd1,        1'b0, '0},
         '{ROW_THRESHOLD, 32'h7FFFFFFF, 1'b0, '0},
         '{ROW_SAMPLE,    SAMPLE_MIN,   1'b0, '0},
         '{ROW_SAMPLE,    SAMPLE_MAX,   1'b0, '0},
         '{ROW_SAMPLE,    32'd0,        1'b0, '0},
         '{ROW_SAMPLE,    SAMPLE_MAX,   1'b0, '0},
         '{ROW_THRESHOLD, 32'd5,        1'b0, '0},
         '{ROW_SAMPLE,    32'd100,      1'b0, '0},
         '{ROW_SAMPLE,    32'd100,      1'b0, '0},
         '{ROW_SAMPLE,    32'd106,      1'b0, '0},
         '{ROW_SAMPLE,    32'd105,      1'b0, '0},
         '{ROW_SAMPLE,    -32'sd100,    1'b0, '0},
         '{ROW_SAMPLE,    32'd100,      1'b0, '0},
         '{ROW_THRESHOLD, 32'd0,        1'b0, '0},
         '{ROW_SAMPLE,    32'd7,        1'b0, '0},
         '{ROW_SAMPLE,    32'd7,        1'b0, '0},
         '{ROW_SAMPLE,    32'd7,        1'b1, 32'sd7},
         '{ROW_SAMPLE,    32'd8,        1'b1, 32'sd7}
      };
      foreach (ring_copy[i])
         ring_copy[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_THRESHOLD)
            write_threshold(m3if_pkg::thresh_type'(directed_rows[i].value));
         else
            send_sample(m3if_pkg::sample_type'(directed_rows[i].value),
                        directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases, each under its own threshold and idling pattern.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 5)
            0:       write_threshold(THRESH_MAX);
            1:       write_threshold('0);
            2:       write_threshold(m3if_pkg::thresh_type'($urandom_range(1, 64)));
            3:       write_threshold(m3if_pkg::thresh_type'($urandom_range(0, 1 << 20)));
            default: write_threshold(m3if_pkg::thresh_type'($urandom()));
         endcase
         noise_span   = longint'(impulse_limit) + 8;
         signal_level = longint'(m3if_pkg::sample_type'($urandom()));
         tx_idle      = (phase % 2) != 0;
         rx_idle      <= ((phase / 2) % 2) != 0;
         if (phase == 5) begin
            // Back-to-back offers while the result side holds off.
            tx_idle      = 1'b0;
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
         end
         repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
